FILE: rtl/mi3x3_pkg.sv
// Shared constants and transaction types of the 3x3 mutual information block.
package mi3x3_pkg;

   localparam int COUNT_BITS    = 16;
   localparam int CELLS         = 9;
   localparam int TERMS         = 16;
   localparam int SUM_BITS      = 20;
   localparam int FRAC_BITS     = 24;
   localparam int GUARD_BITS    = 8;
   localparam int LOG_FRAC      = FRAC_BITS + GUARD_BITS;
   localparam int LOG_INT_BITS  = 5;
   localparam int LOG_BITS      = LOG_INT_BITS + LOG_FRAC;
   localparam int M_BITS        = 63;
   localparam int SQ_STAGES     = LOG_FRAC;
   localparam int Q_BITS        = LOG_BITS;
   localparam int DIVD_BITS     = SUM_BITS + Q_BITS;
   localparam int DIV_PER_STAGE = 4;
   localparam int DIV_STAGES    = (Q_BITS + DIV_PER_STAGE - 1) / DIV_PER_STAGE;
   localparam int ACC_BITS      = Q_BITS + 4;
   localparam int OUT_BITS      = FRAC_BITS + 1;
   localparam int REQ_BITS      = CELLS * COUNT_BITS;
   localparam int RSP_BITS      = 32;

   localparam logic [63:0] LN2_Q64 = 64'hB17217F7D1CF79AC;
   localparam logic [63:0] LG2_Q64 = 64'h4D104D427DE7FBCC;

   localparam logic [3:0] IDX_TOTAL     = 4'd0;
   localparam logic [3:0] IDX_FIRST_NEG = 4'd7;
   localparam logic [3:0] IDX_LAST      = 4'd15;

   typedef enum logic [1:0] {
      KIND_TOTAL,
      KIND_POS,
      KIND_NEG
   } kind_type;

   typedef struct packed {
      logic                valid;
      kind_type            kind;
      logic                last;
      logic                empty;
      logic                zero;
      logic [SUM_BITS-1:0] c;
      logic [SUM_BITS-1:0] tot;
   } hdr_type;

   typedef struct packed {
      hdr_type             h;
      logic [Q_BITS-1:0]   term;
   } res_type;

endpackage

FILE: rtl/mi3x3_term_pipe.sv
// Pipelined count*log(total/count)/total term unit, one term per cycle while advance is high.
module mi3x3_term_pipe (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                log_base,
   input  mi3x3_pkg::hdr_type  in_tok,
   output mi3x3_pkg::res_type  out_tok
);

   typedef struct packed {
      mi3x3_pkg::hdr_type                  h;
      logic [mi3x3_pkg::M_BITS-1:0]        m;
      logic [mi3x3_pkg::LOG_BITS-1:0]      res;
   } lg_type;

   typedef struct packed {
      mi3x3_pkg::hdr_type                  h;
      logic [61:0]                         p2;
      logic [62:0]                         p1;
      logic [63:0]                         p0;
      logic [mi3x3_pkg::LOG_BITS-1:0]      res;
   } sq_type;

   typedef struct packed {
      mi3x3_pkg::hdr_type                  h;
      logic [63:0]                         pll;
      logic [63:0]                         plh;
      logic [36:0]                         phl;
      logic [36:0]                         phh;
   } sc_type;

   typedef struct packed {
      mi3x3_pkg::hdr_type                  h;
      logic [mi3x3_pkg::LOG_BITS-1:0]      lv;
   } lo_type;

   typedef struct packed {
      mi3x3_pkg::hdr_type                  h;
      logic [51:0]                         plo;
      logic [24:0]                         phi;
   } mp_type;

   typedef struct packed {
      mi3x3_pkg::hdr_type                  h;
      logic [mi3x3_pkg::SUM_BITS:0]        rem;
      logic [mi3x3_pkg::Q_BITS-1:0]        q;
   } dv_type;

   lg_type lg_ff [0:mi3x3_pkg::SQ_STAGES];
   lg_type lg_in [0:mi3x3_pkg::SQ_STAGES];
   sq_type sq_ff [0:mi3x3_pkg::SQ_STAGES-1];
   sq_type sq_in [0:mi3x3_pkg::SQ_STAGES-1];
   sc_type sc_ff, sc_in;
   lo_type lo_ff, lo_in;
   lo_type df_ff, df_in;
   mp_type mp_ff, mp_in;
   dv_type dv_ff [0:mi3x3_pkg::DIV_STAGES];
   dv_type dv_in [0:mi3x3_pkg::DIV_STAGES];
   logic [mi3x3_pkg::LOG_BITS-1:0] lt_ff;

   logic [mi3x3_pkg::LOG_INT_BITS-1:0] msb;
   logic [125:0]                       full;
   logic [63:0]                        mq;
   logic [63:0]                        kc;
   logic [103:0]                       scs;
   logic [mi3x3_pkg::DIVD_BITS-1:0]    dvd;
   dv_type                             dx;
   logic [mi3x3_pkg::SUM_BITS:0]       rs;

   always_comb begin
      msb = '0;
      for (int b = 0; b < mi3x3_pkg::SUM_BITS; b++) begin
         if (in_tok.c[b]) msb = mi3x3_pkg::LOG_INT_BITS'(b);
      end
      lg_in[0].h   = in_tok;
      lg_in[0].m   = mi3x3_pkg::M_BITS'(in_tok.c) << (6'(mi3x3_pkg::M_BITS - 1) - 6'(msb));
      lg_in[0].res = {msb, mi3x3_pkg::LOG_FRAC'(0)};

      full = '0;
      mq   = '0;
      for (int it = 0; it < mi3x3_pkg::SQ_STAGES; it++) begin
         sq_in[it].h   = lg_ff[it].h;
         sq_in[it].res = lg_ff[it].res;
         sq_in[it].p2  = 62'(lg_ff[it].m[62:32]) * 62'(lg_ff[it].m[62:32]);
         sq_in[it].p1  = 63'(lg_ff[it].m[62:32]) * 63'(lg_ff[it].m[31:0]);
         sq_in[it].p0  = 64'(lg_ff[it].m[31:0]) * 64'(lg_ff[it].m[31:0]);

         full = {sq_ff[it].p2, 64'd0} + 126'({sq_ff[it].p1, 33'd0}) + 126'(sq_ff[it].p0);
         mq   = full[125:62];
         lg_in[it+1].h   = sq_ff[it].h;
         lg_in[it+1].res = sq_ff[it].res;
         if (mq[63]) begin
            lg_in[it+1].res[mi3x3_pkg::LOG_FRAC-1-it] = 1'b1;
            lg_in[it+1].m = mq[63:1];
         end else begin
            lg_in[it+1].m = mq[62:0];
         end
      end

      kc = log_base ? mi3x3_pkg::LG2_Q64 : mi3x3_pkg::LN2_Q64;
      sc_in.h   = lg_ff[mi3x3_pkg::SQ_STAGES].h;
      sc_in.pll = 64'(lg_ff[mi3x3_pkg::SQ_STAGES].res[31:0]) * 64'(kc[31:0]);
      sc_in.plh = 64'(lg_ff[mi3x3_pkg::SQ_STAGES].res[31:0]) * 64'(kc[63:32]);
      sc_in.phl = 37'(lg_ff[mi3x3_pkg::SQ_STAGES].res[36:32]) * 37'(kc[31:0]);
      sc_in.phh = 37'(lg_ff[mi3x3_pkg::SQ_STAGES].res[36:32]) * 37'(kc[63:32]);

      scs = 104'(sc_ff.pll) + 104'({sc_ff.plh, 32'd0}) + 104'({sc_ff.phl, 32'd0})
          + 104'({sc_ff.phh, 64'd0});
      lo_in.h  = sc_ff.h;
      lo_in.lv = scs[100:64];

      df_in.h  = lo_ff.h;
      df_in.lv = (lt_ff > lo_ff.lv) ? lt_ff - lo_ff.lv : '0;

      mp_in.h   = df_ff.h;
      mp_in.plo = 52'(df_ff.h.c) * 52'(df_ff.lv[31:0]);
      mp_in.phi = 25'(df_ff.h.c) * 25'(df_ff.lv[36:32]);

      dvd = mi3x3_pkg::DIVD_BITS'(mp_ff.plo) + mi3x3_pkg::DIVD_BITS'({mp_ff.phi, 32'd0});
      dv_in[0].h   = mp_ff.h;
      dv_in[0].rem = {1'b0, dvd[mi3x3_pkg::DIVD_BITS-1:mi3x3_pkg::Q_BITS]};
      dv_in[0].q   = dvd[mi3x3_pkg::Q_BITS-1:0];

      dx = '0;
      rs = '0;
      for (int s = 0; s < mi3x3_pkg::DIV_STAGES; s++) begin
         dx = dv_ff[s];
         for (int j = 0; j < mi3x3_pkg::DIV_PER_STAGE; j++) begin
            if (s * mi3x3_pkg::DIV_PER_STAGE + j < mi3x3_pkg::Q_BITS) begin
               rs   = {dx.rem[mi3x3_pkg::SUM_BITS-1:0], dx.q[mi3x3_pkg::Q_BITS-1]};
               dx.q = {dx.q[mi3x3_pkg::Q_BITS-2:0], 1'b0};
               if (rs >= {1'b0, dx.h.tot}) begin
                  rs      = rs - {1'b0, dx.h.tot};
                  dx.q[0] = 1'b1;
               end
               dx.rem = rs;
            end
         end
         dv_in[s+1] = dx;
      end

      out_tok.h    = dv_ff[mi3x3_pkg::DIV_STAGES].h;
      out_tok.term = dv_ff[mi3x3_pkg::DIV_STAGES].q;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= mi3x3_pkg::SQ_STAGES; i++) lg_ff[i].h.valid <= 1'b0;
         for (int i = 0; i < mi3x3_pkg::SQ_STAGES; i++) sq_ff[i].h.valid <= 1'b0;
         for (int i = 0; i <= mi3x3_pkg::DIV_STAGES; i++) dv_ff[i].h.valid <= 1'b0;
         sc_ff.h.valid <= 1'b0;
         lo_ff.h.valid <= 1'b0;
         df_ff.h.valid <= 1'b0;
         mp_ff.h.valid <= 1'b0;
      end else if (advance) begin
         lg_ff <= lg_in;
         sq_ff <= sq_in;
         sc_ff <= sc_in;
         lo_ff <= lo_in;
         df_ff <= df_in;
         mp_ff <= mp_in;
         dv_ff <= dv_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && lo_ff.h.valid && lo_ff.h.kind == mi3x3_pkg::KIND_TOTAL) begin
         lt_ff <= lo_ff.lv;
      end
   end

endmodule

FILE: rtl/mutual_information_3x3.sv
// Top level of the 3x3 contingency table mutual information block.
//
//   channel  direction  handshake                 payload
//   req      in         req_tvalid / req_tready   req_tdata: nine 16-bit counts
//   rsp      out        rsp_tvalid / rsp_tready   rsp_tdata, rsp_tuser
//   csr      in         csr_valid / csr_ready     csr_data: log_base
//
// A new table is taken while the last term of the previous one is issued, or when
// idle: the shared term pipeline is fed the log of the total and then one of the
// 15 terms per cycle while the result is not held; an empty table issues only the total.
// Reset clears all valid bits and selects the natural logarithm.
// A held result freezes the whole pipeline; nothing is dropped or repeated.
module mutual_information_3x3 (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // count_r0c0, count_r0c1, ... count_r2c2, 16 bits each
   input  logic [mi3x3_pkg::REQ_BITS-1:0]    req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // mutual_info [24:0], zero fill
   output logic [mi3x3_pkg::RSP_BITS-1:0]    rsp_tdata,
   // empty_table
   output logic [0:0]                        rsp_tuser,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [0:0]                        csr_data
);

   typedef struct packed {
      logic                              valid;
      logic                              empty;
      logic [mi3x3_pkg::ACC_BITS-1:0]    pos;
      logic [mi3x3_pkg::ACC_BITS-1:0]    neg;
   } fin_type;

   localparam logic [32:0] MI_MAX = 33'((64'd1 << mi3x3_pkg::OUT_BITS) - 64'd1);

   logic                              log_base_ff;
   logic                              busy_ff, busy_in;
   logic [3:0]                        cnt_ff, cnt_in;
   logic                              empty_ff, empty_in;
   logic [mi3x3_pkg::SUM_BITS-1:0]    tot_ff, tot_in;
   logic [mi3x3_pkg::SUM_BITS-1:0]    vals_ff [0:mi3x3_pkg::TERMS-1];
   logic [mi3x3_pkg::SUM_BITS-1:0]    vals_in [0:mi3x3_pkg::TERMS-1];
   logic [mi3x3_pkg::ACC_BITS-1:0]    pos_ff, pos_in, neg_ff, neg_in;
   fin_type                           fin_ff, fin_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [mi3x3_pkg::OUT_BITS-1:0]    mi_ff, mi_in;
   logic                              rsp_empty_ff, rsp_empty_in;

   logic                              advance;
   logic                              last_issue;
   logic                              accept;
   logic [mi3x3_pkg::SUM_BITS-1:0]    rows [0:2];
   logic [mi3x3_pkg::SUM_BITS-1:0]    cols [0:2];
   mi3x3_pkg::hdr_type                issue;
   mi3x3_pkg::res_type                term_tok;
   logic [mi3x3_pkg::ACC_BITS-1:0]    tv;
   logic [mi3x3_pkg::ACC_BITS-1:0]    diff;
   logic [32:0]                       shifted;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign last_issue = empty_ff || cnt_ff == mi3x3_pkg::IDX_LAST;
   assign req_tready = advance && (!busy_ff || last_issue);
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         rows[r] = mi3x3_pkg::SUM_BITS'(req_tdata[(3*r)*16 +: 16])
                 + mi3x3_pkg::SUM_BITS'(req_tdata[(3*r+1)*16 +: 16])
                 + mi3x3_pkg::SUM_BITS'(req_tdata[(3*r+2)*16 +: 16]);
         cols[r] = mi3x3_pkg::SUM_BITS'(req_tdata[r*16 +: 16])
                 + mi3x3_pkg::SUM_BITS'(req_tdata[(r+3)*16 +: 16])
                 + mi3x3_pkg::SUM_BITS'(req_tdata[(r+6)*16 +: 16]);
      end
      tot_in   = tot_ff;
      empty_in = empty_ff;
      busy_in  = busy_ff;
      cnt_in   = cnt_ff;
      vals_in  = vals_ff;
      if (accept) begin
         tot_in   = rows[0] + rows[1] + rows[2];
         empty_in = (rows[0] + rows[1] + rows[2]) == '0;
         busy_in  = 1'b1;
         cnt_in   = '0;
         vals_in[0] = rows[0] + rows[1] + rows[2];
         for (int r = 0; r < 3; r++) begin
            vals_in[1+r] = rows[r];
            vals_in[4+r] = cols[r];
         end
         for (int i = 0; i < mi3x3_pkg::CELLS; i++) begin
            vals_in[7+i] = mi3x3_pkg::SUM_BITS'(req_tdata[i*16 +: 16]);
         end
      end else if (busy_ff) begin
         for (int i = 0; i < mi3x3_pkg::TERMS-1; i++) vals_in[i] = vals_ff[i+1];
         cnt_in = cnt_ff + 4'd1;
         if (last_issue) busy_in = 1'b0;
      end

      issue.valid = busy_ff;
      if (cnt_ff == mi3x3_pkg::IDX_TOTAL) issue.kind = mi3x3_pkg::KIND_TOTAL;
      else if (cnt_ff < mi3x3_pkg::IDX_FIRST_NEG) issue.kind = mi3x3_pkg::KIND_POS;
      else issue.kind = mi3x3_pkg::KIND_NEG;
      issue.last  = last_issue;
      issue.empty = empty_ff;
      issue.zero  = vals_ff[0] == '0;
      issue.c     = vals_ff[0];
      issue.tot   = tot_ff;
   end

   mi3x3_term_pipe u_term (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .log_base (log_base_ff),
      .in_tok   (issue),
      .out_tok  (term_tok)
   );

   always_comb begin
      tv     = term_tok.h.zero ? '0 : mi3x3_pkg::ACC_BITS'(term_tok.term);
      pos_in = pos_ff;
      neg_in = neg_ff;
      if (term_tok.h.valid) begin
         case (term_tok.h.kind)
            mi3x3_pkg::KIND_TOTAL: begin
               pos_in = '0;
               neg_in = '0;
            end
            mi3x3_pkg::KIND_POS: pos_in = pos_ff + tv;
            default:             neg_in = neg_ff + tv;
         endcase
      end
      fin_in.valid = term_tok.h.valid && term_tok.h.last;
      fin_in.empty = term_tok.h.empty;
      fin_in.pos   = pos_in;
      fin_in.neg   = neg_in;

      diff    = fin_ff.pos - fin_ff.neg
              + mi3x3_pkg::ACC_BITS'(1 << (mi3x3_pkg::GUARD_BITS - 1));
      shifted = 33'(diff >> mi3x3_pkg::GUARD_BITS);
      if (fin_ff.empty || fin_ff.pos <= fin_ff.neg) mi_in = '0;
      else if (shifted > MI_MAX) mi_in = MI_MAX[mi3x3_pkg::OUT_BITS-1:0];
      else mi_in = shifted[mi3x3_pkg::OUT_BITS-1:0];
      rsp_empty_in = fin_ff.empty;
      rsp_valid_in = fin_ff.valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         log_base_ff  <= 1'b0;
         busy_ff      <= 1'b0;
         cnt_ff       <= '0;
         fin_ff.valid <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) log_base_ff <= csr_data[0];
         if (advance) begin
            busy_ff      <= busy_in;
            cnt_ff       <= cnt_in;
            tot_ff       <= tot_in;
            empty_ff     <= empty_in;
            vals_ff      <= vals_in;
            pos_ff       <= pos_in;
            neg_ff       <= neg_in;
            fin_ff       <= fin_in;
            rsp_valid_ff <= rsp_valid_in;
            mi_ff        <= mi_in;
            rsp_empty_ff <= rsp_empty_in;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = mi3x3_pkg::RSP_BITS'(mi_ff);
   assign rsp_tuser  = rsp_empty_ff;

`ifndef SYNTHESIS
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("empty table result not zero");
   a_ready_adv: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> advance)
      else $error("input taken while pipeline held");
   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      term_tok.h.valid && term_tok.h.last |->
         term_tok.h.kind == mi3x3_pkg::KIND_NEG || term_tok.h.empty)
      else $error("last term of a table has wrong kind");
   a_idle_cnt: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy_ff && cnt_ff == mi3x3_pkg::IDX_TOTAL)
      else $error("sequencer did not restart on a new table");
`endif

endmodule

FILE: tb/mi3x3_checker.sv
`timescale 1ns / 100ps
// Checker for the 3x3 mutual information block: predicts each result and compares it.
module mi3x3_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [mi3x3_pkg::REQ_BITS-1:0] req_tdata,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [mi3x3_pkg::RSP_BITS-1:0] rsp_tdata,
   input  logic [0:0]                     rsp_tuser,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [0:0]                     csr_data,
   output int                             fails,
   output int                             pending
);

   typedef struct packed {
      logic [mi3x3_pkg::OUT_BITS-1:0] info;
      logic                           empty;
   } mi_result_type;

   mi_result_type mi_expected[$];
   logic          base_sel;

   function automatic logic [63:0] log_fixed(logic [63:0] x, logic sel);
      int          top;
      logic [63:0] m;
      logic [63:0] res;
      logic [127:0] sq;
      top = 0;
      for (int i = 0; i < 64; i++)
         if (x[i]) top = i;
      m   = x << (62 - top);
      res = 64'(top) << mi3x3_pkg::LOG_FRAC;
      for (int i = mi3x3_pkg::LOG_FRAC - 1; i >= 0; i--) begin
         sq = {64'b0, m} * {64'b0, m};
         m  = sq[125:62];
         if (m[63]) begin
            res[i] = 1'b1;
            m = m >> 1;
         end
      end
      sq = {64'b0, res} * {64'b0, (sel ? mi3x3_pkg::LG2_Q64 : mi3x3_pkg::LN2_Q64)};
      return sq[127:64];
   endfunction

   function automatic logic [63:0] entropy_term(logic [63:0] c, logic [63:0] total,
                                                logic [63:0] lt, logic sel);
      logic [63:0]  lc;
      logic [63:0]  d;
      logic [127:0] prod;
      if (c == 0) return 64'd0;
      lc   = log_fixed(c, sel);
      d    = (lt > lc) ? lt - lc : 64'd0;
      prod = {64'b0, c} * {64'b0, d};
      return 64'(prod / {64'b0, total});
   endfunction

   function automatic mi_result_type predict_mi(logic [mi3x3_pkg::REQ_BITS-1:0] data,
                                                logic sel);
      logic [63:0]   cnt[9];
      logic [63:0]   row[3];
      logic [63:0]   col[3];
      logic [63:0]   total;
      logic [63:0]   lt;
      logic [63:0]   pos;
      logic [63:0]   neg;
      logic [63:0]   mi;
      mi_result_type r;
      total = 0;
      pos   = 0;
      neg   = 0;
      mi    = 0;
      for (int i = 0; i < 9; i++)
         cnt[i] = 64'(data[i*mi3x3_pkg::COUNT_BITS +: mi3x3_pkg::COUNT_BITS]);
      for (int i = 0; i < 3; i++) begin
         row[i] = cnt[i*3] + cnt[i*3+1] + cnt[i*3+2];
         col[i] = cnt[i] + cnt[i+3] + cnt[i+6];
         total += row[i];
      end
      if (total == 0) begin
         r.info  = '0;
         r.empty = 1'b1;
         return r;
      end
      lt = log_fixed(total, sel);
      for (int i = 0; i < 3; i++) begin
         pos += entropy_term(row[i], total, lt, sel);
         pos += entropy_term(col[i], total, lt, sel);
      end
      for (int i = 0; i < 9; i++)
         neg += entropy_term(cnt[i], total, lt, sel);
      if (pos > neg) begin
         mi = (pos - neg + (64'd1 << (mi3x3_pkg::GUARD_BITS - 1))) >> mi3x3_pkg::GUARD_BITS;
         if (mi > (64'd1 << mi3x3_pkg::OUT_BITS) - 1)
            mi = (64'd1 << mi3x3_pkg::OUT_BITS) - 1;
      end
      r.info  = mi[mi3x3_pkg::OUT_BITS-1:0];
      r.empty = 1'b0;
      return r;
   endfunction

   assign pending = mi_expected.size();

   always @(posedge clock) begin
      mi_result_type want;
      int            errs;
      errs = 0;
      if (reset) begin
         base_sel <= 1'b0;
         fails    <= 0;
         mi_expected.delete();
      end else begin
         if (csr_valid && csr_ready) base_sel <= csr_data[0];
         if (req_tvalid && req_tready) mi_expected.push_back(predict_mi(req_tdata, base_sel));
         if (rsp_tvalid && rsp_tready) begin
            if (mi_expected.size() == 0) begin
               $error("unexpected result transaction: mutual_info %0d empty_table %0d",
                      rsp_tdata[mi3x3_pkg::OUT_BITS-1:0], rsp_tuser[0]);
               errs++;
            end else begin
               want = mi_expected.pop_front();
               if (rsp_tdata[mi3x3_pkg::OUT_BITS-1:0] !== want.info) begin
                  $error("mutual_info expected %0d actual %0d", want.info,
                         rsp_tdata[mi3x3_pkg::OUT_BITS-1:0]);
                  errs++;
               end
               if (rsp_tuser[0] !== want.empty) begin
                  $error("empty_table expected %0d actual %0d", want.empty, rsp_tuser[0]);
                  errs++;
               end
            end
         end
         if (errs != 0) fails <= fails + errs;
      end
   end

endmodule

FILE: tb/tb_mutual_information_3x3.sv
`timescale 1ns / 100ps
// Stimulus and verdict for the 3x3 mutual information block.
module tb_mutual_information_3x3;

   localparam int CYCLE_LIMIT = 1000000;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [mi3x3_pkg::REQ_BITS-1:0] req_tdata = '0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [mi3x3_pkg::RSP_BITS-1:0] rsp_tdata;
   logic [0:0]                     rsp_tuser;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [0:0]                     csr_data = '0;
   int                             fails;
   int                             pending;
   int                             cycles = 0;
   int                             gap_pct = 11;

   always #10 clock = ~clock;

   mutual_information_3x3 dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   mi3x3_checker u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data),
      .fails(fails), .pending(pending)
   );

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_mutual_information_3x3 failed");
         $finish;
      end
   end

   // receiver: long hold-off, then a stretch always ready, random idling otherwise
   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else if (cycles >= 3000 && cycles < 3600) rsp_tready <= 1'b0;
      else if (cycles >= 8000 && cycles < 11000) rsp_tready <= 1'b1;
      else rsp_tready <= ($urandom_range(99) >= 11);
   end

   task automatic send_table(logic [mi3x3_pkg::REQ_BITS-1:0] data);
      logic ok;
      while (cycles < 14000 || cycles >= 17000) begin
         if ($urandom_range(99) >= gap_pct) break;
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      do begin
         @(negedge clock);
         ok = req_tready;
         @(posedge clock);
      end while (!ok);
   endtask

   task automatic write_base(logic sel);
      logic ok;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= sel;
      do begin
         @(negedge clock);
         ok = csr_ready;
         @(posedge clock);
      end while (!ok);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [mi3x3_pkg::REQ_BITS-1:0] cells(int a, int b, int c, int d,
                                                            int e, int f, int g, int h,
                                                            int i);
      return {16'(i), 16'(h), 16'(g), 16'(f), 16'(e), 16'(d), 16'(c), 16'(b), 16'(a)};
   endfunction

   function automatic logic [mi3x3_pkg::REQ_BITS-1:0] random_table();
      logic [mi3x3_pkg::REQ_BITS-1:0] t;
      int                             mode;
      logic [15:0]                    pick[4];
      mode = $urandom_range(4);
      pick = '{16'd0, 16'd1, 16'hFFFE, 16'hFFFF};
      for (int k = 0; k < 9; k++) begin
         case (mode)
            0: t[k*16 +: 16] = 16'($urandom);
            1: t[k*16 +: 16] = 16'($urandom_range(15));
            2: t[k*16 +: 16] = $urandom_range(1) ? 16'($urandom) : 16'd0;
            3: t[k*16 +: 16] = pick[$urandom_range(3)];
            default: t[k*16 +: 16] = (k % 4 == 0) ? 16'($urandom) : 16'($urandom_range(3));
         endcase
      end
      return t;
   endfunction

   task automatic directed_tables();
      send_table(cells(0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_table(cells(65535, 65535, 65535, 65535, 65535, 65535, 65535, 65535, 65535));
      send_table(cells(1, 0, 0, 0, 0, 0, 0, 0, 0));
      send_table(cells(0, 0, 0, 0, 0, 0, 0, 0, 65535));
      send_table(cells(65535, 0, 0, 0, 65535, 0, 0, 0, 65535));
      send_table(cells(1, 0, 0, 0, 1, 0, 0, 0, 1));
      send_table(cells(1, 2, 3, 2, 4, 6, 3, 6, 9));
      send_table(cells(5, 7, 9, 0, 0, 0, 0, 0, 0));
      send_table(cells(65535, 1, 0, 1, 65535, 0, 0, 0, 0));
      send_table(cells(0, 65535, 0, 65535, 0, 0, 0, 0, 1));
      send_table(cells(43690, 21845, 43690, 21845, 43690, 21845, 43690, 21845, 43690));
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      write_base(1'b0);
      directed_tables();
      write_base(1'b1);
      directed_tables();
      for (int phase = 0; phase < 4; phase++) begin
         write_base(phase[0] ? 1'b0 : 1'b1);
         for (int n = 0; n < 500; n++) send_table(random_table());
      end
      req_tvalid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (fails == 0 && pending == 0)
         $display("tb_mutual_information_3x3 passed");
      else
         $display("tb_mutual_information_3x3 failed");
      $finish;
   end

endmodule

FILE: files.f
rtl/mi3x3_pkg.sv
rtl/mi3x3_term_pipe.sv
rtl/mutual_information_3x3.sv
tb/mi3x3_checker.sv
tb/tb_mutual_information_3x3.sv
